[rtl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Command, status and state codes shared by the session slot table.
// ----------------------------------------------------------------------------
package sst_pkg;

	typedef enum logic [2:0] {
		ACT_INIT   = 3'd0,
		ACT_DEINIT = 3'd1,
		ACT_CREATE = 3'd2,
		ACT_CLOSE  = 3'd3,
		ACT_QUERY  = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOT_INIT = 2'd1,
		STAT_INVALID  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	localparam int unsigned SID_W = 16;

endpackage

[rtl/sst_id_ram.sv]
// ----------------------------------------------------------------------------
// sst_id_ram
// Slot id store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sst_id_ram #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned WIDTH = 16,
	parameter int unsigned AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/session_slot_table_unit.sv]
// ----------------------------------------------------------------------------
// session_slot_table_unit
// Session slot table with an id counter: init, deinit, create, close, query.
//
//   channel | direction | handshake             | word
//   cmd     | in        | cmd_valid / cmd_ready | action, session_id
//   rsp     | out       | rsp_valid / rsp_ready | status, new_session_id, is_valid
//
// Init, deinit, create and unknown commands go from idle straight to the
// response state. Close and query read the id RAM one slot a cycle, ending
// at the first matching active slot or at the last slot; with the table off they skip the scan.
// One command is in flight at a time; a new one is taken while the previous
// response waits in the output register. Reset leaves the table off.
// ----------------------------------------------------------------------------
module session_slot_table_unit #(
	parameter int unsigned SLOT_COUNT = 8,
	parameter int unsigned ID_BITS    = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  logic [2:0]              action,
	input  logic [sst_pkg::SID_W-1:0] session_id,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic [1:0]              status,
	output logic [sst_pkg::SID_W-1:0] new_session_id,
	output logic                    is_valid
);

	localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CMP_W = (ID_BITS > sst_pkg::SID_W) ? ID_BITS : sst_pkg::SID_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	sst_pkg::state_t                state_q;
	logic                           table_on_q;
	logic [ID_BITS-1:0]             next_id_q;
	logic [SLOT_COUNT-1:0]          active_q;
	logic [2:0]                     act_q;
	logic [sst_pkg::SID_W-1:0]      sid_q;
	logic [IDX_W-1:0]               idx_q;
	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               idx_s1;
	logic [1:0]                     res_status_q;
	logic [sst_pkg::SID_W-1:0]      res_new_id_q;
	logic                           res_valid_q;

	logic                           free_found;
	logic [IDX_W-1:0]               free_idx;
	logic [ID_BITS-1:0]             id_inc;
	logic [ID_BITS-1:0]             next_id_adv;
	logic [ID_BITS-1:0]             rd_id;
	logic                           hit;
	logic                           cmd_fire;
	logic                           create_we;

	assign cmd_ready = (state_q == sst_pkg::ST_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign id_inc      = next_id_q + ID_BITS'(1);
	assign next_id_adv = (id_inc == '0) ? ID_BITS'(1) : id_inc;
	assign create_we   = cmd_fire && (action == sst_pkg::ACT_CREATE) && table_on_q && free_found;
	assign hit         = rd_vld_s1 && active_q[idx_s1] && (CMP_W'(rd_id) == CMP_W'(sid_q));

	sst_id_ram #(
		.DEPTH(SLOT_COUNT),
		.WIDTH(ID_BITS),
		.AW   (IDX_W)
	) u_id_ram (
		.clk  (clk),
		.we   (create_we),
		.waddr(free_idx),
		.wdata(next_id_q),
		.raddr(idx_q),
		.rdata(rd_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sst_pkg::ST_IDLE;
			table_on_q     <= 1'b0;
			next_id_q      <= ID_BITS'(1);
			active_q       <= '0;
			act_q          <= '0;
			sid_q          <= '0;
			idx_q          <= '0;
			rd_vld_s1      <= 1'b0;
			idx_s1         <= '0;
			res_status_q   <= sst_pkg::STAT_OK;
			res_new_id_q   <= '0;
			res_valid_q    <= 1'b0;
			rsp_valid      <= 1'b0;
			status         <= sst_pkg::STAT_OK;
			new_session_id <= '0;
			is_valid       <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				sst_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						act_q        <= action;
						sid_q        <= session_id;
						res_status_q <= sst_pkg::STAT_OK;
						res_new_id_q <= '0;
						res_valid_q  <= 1'b0;
						state_q      <= sst_pkg::ST_RESP;
						case (action)
							sst_pkg::ACT_INIT: begin
								if (!table_on_q) begin
									active_q   <= '0;
									next_id_q  <= ID_BITS'(1);
									table_on_q <= 1'b1;
								end
							end
							sst_pkg::ACT_DEINIT: begin
								if (!table_on_q) begin
									res_status_q <= sst_pkg::STAT_NOT_INIT;
								end else begin
									active_q   <= '0;
									table_on_q <= 1'b0;
								end
							end
							sst_pkg::ACT_CREATE: begin
								if (!table_on_q) begin
									res_status_q <= sst_pkg::STAT_NOT_INIT;
								end else if (free_found) begin
									active_q[free_idx] <= 1'b1;
									res_new_id_q       <= sst_pkg::SID_W'(next_id_q);
									next_id_q          <= next_id_adv;
								end else begin
									res_status_q <= sst_pkg::STAT_INVALID;
								end
							end
							sst_pkg::ACT_CLOSE, sst_pkg::ACT_QUERY: begin
								if (!table_on_q) begin
									res_status_q <= sst_pkg::STAT_NOT_INIT;
								end else begin
									idx_q     <= '0;
									rd_vld_s1 <= 1'b0;
									state_q   <= sst_pkg::ST_SCAN;
								end
							end
							default: begin
								res_status_q <= sst_pkg::STAT_INVALID;
							end
						endcase
					end
				end
				sst_pkg::ST_SCAN: begin
					rd_vld_s1 <= 1'b1;
					idx_s1    <= idx_q;
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IDX_W'(1);
					end
					if (hit) begin
						if (act_q == sst_pkg::ACT_CLOSE) begin
							active_q[idx_s1] <= 1'b0;
						end else begin
							res_valid_q <= 1'b1;
						end
						rd_vld_s1 <= 1'b0;
						state_q   <= sst_pkg::ST_RESP;
					end else if (rd_vld_s1 && (idx_s1 == LAST_IDX)) begin
						if (act_q == sst_pkg::ACT_CLOSE) begin
							res_status_q <= sst_pkg::STAT_INVALID;
						end
						rd_vld_s1 <= 1'b0;
						state_q   <= sst_pkg::ST_RESP;
					end
				end
				sst_pkg::ST_RESP: begin
					if (!rsp_valid || rsp_ready) begin
						rsp_valid      <= 1'b1;
						status         <= res_status_q;
						new_session_id <= res_new_id_q;
						is_valid       <= res_valid_q;
						state_q        <= sst_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sst_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// counter never lands on the invalid id
	a_next_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("next id is zero");

	// a scan only runs with the table on
	a_scan_on: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::ST_SCAN) |-> table_on_q)
		else $error("scan with table off");

	// a successful create takes exactly one slot
	a_create_one: assert property (@(posedge clk) disable iff (!arst_n)
		create_we |=> ($countones(active_q) == $past($countones(active_q)) + 1))
		else $error("create did not take one slot");

	// a failed word carries no id and no query answer
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != sst_pkg::STAT_OK)) |-> (new_session_id == '0 && !is_valid))
		else $error("failed word carries data");

	// table off means no active slot
	a_off_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!table_on_q |-> (active_q == '0))
		else $error("active slot with table off");

endmodule

[sim/session_slot_table_checker.sv]
// ----------------------------------------------------------------------------
// session_slot_table_checker
// Watches the cmd and rsp channels of the session slot table. Each accepted
// cmd word runs through a local copy of the slot table and id counter. The
// answer it gives is queued and compared field by field with the next
// accepted rsp word. The mismatch count and the number of answers still
// owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module session_slot_table_checker #(
	parameter int unsigned SLOTS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  logic                      cmd_ready,
	input  logic [2:0]                action,
	input  logic [sst_pkg::SID_W-1:0] session_id,
	input  logic                      rsp_valid,
	input  logic                      rsp_ready,
	input  logic [1:0]                status,
	input  logic [sst_pkg::SID_W-1:0] new_session_id,
	input  logic                      is_valid,
	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		sst_pkg::stat_t            status;
		logic [sst_pkg::SID_W-1:0] new_id;
		logic                      valid;
	} answer_t;

	logic                      table_on;
	logic [sst_pkg::SID_W-1:0] next_id;
	logic                      slot_busy [SLOTS];
	logic [sst_pkg::SID_W-1:0] slot_sid  [SLOTS];
	answer_t                   answers_q [$];
	answer_t                   want;
	int                        rsp_count;

	function automatic void clear_slots();
		for (int i = 0; i < SLOTS; i++) begin
			slot_busy[i] = 1'b0;
			slot_sid[i]  = '0;
		end
	endfunction

	function automatic int find_busy(logic [sst_pkg::SID_W-1:0] sid);
		int hit;
		hit = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && slot_busy[i] && slot_sid[i] == sid)
				hit = i;
		end
		return hit;
	endfunction

	// advances the table by one command and returns the answer it owes
	function automatic answer_t apply_command(logic [2:0] act,
			logic [sst_pkg::SID_W-1:0] sid);
		answer_t a;
		int      hit;
		a   = '{status: sst_pkg::STAT_OK, new_id: '0, valid: 1'b0};
		hit = -1;
		if (act > sst_pkg::ACT_QUERY) begin
			a.status = sst_pkg::STAT_INVALID;
		end else if (act == sst_pkg::ACT_INIT) begin
			if (!table_on) begin
				clear_slots();
				next_id  = sst_pkg::SID_W'(1);
				table_on = 1'b1;
			end
		end else if (!table_on) begin
			a.status = sst_pkg::STAT_NOT_INIT;
		end else begin
			case (act)
				sst_pkg::ACT_DEINIT: begin
					clear_slots();
					table_on = 1'b0;
				end
				sst_pkg::ACT_CREATE: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (hit < 0 && !slot_busy[i])
							hit = i;
					end
					if (hit < 0) begin
						a.status = sst_pkg::STAT_INVALID;
					end else begin
						slot_busy[hit] = 1'b1;
						slot_sid[hit]  = next_id;
						a.new_id       = next_id;
						next_id        = next_id + 1'b1;
						// id 0 is never handed out
						if (next_id == '0)
							next_id = sst_pkg::SID_W'(1);
					end
				end
				sst_pkg::ACT_CLOSE: begin
					hit = find_busy(sid);
					if (hit < 0) begin
						a.status = sst_pkg::STAT_INVALID;
					end else begin
						slot_busy[hit] = 1'b0;
						slot_sid[hit]  = '0;
					end
				end
				default: begin
					a.valid = (find_busy(sid) >= 0);
				end
			endcase
		end
		return a;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("rsp word %0d: %s is %0h, expected %0h", rsp_count, field, got, exp_val);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_on = 1'b0;
			next_id  = sst_pkg::SID_W'(1);
			clear_slots();
			answers_q.delete();
			pending   = 0;
			errors    = 0;
			rsp_count = 0;
		end else begin
			// a response can never belong to a command taken on the same edge
			if (rsp_valid && rsp_ready) begin
				if (answers_q.size() == 0) begin
					report_mismatch("unexpected word, status", status, '0);
				end else begin
					want = answers_q.pop_front();
					pending--;
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (new_session_id !== want.new_id)
						report_mismatch("new_session_id", new_session_id, want.new_id);
					if (is_valid !== want.valid)
						report_mismatch("is_valid", is_valid, want.valid);
				end
				rsp_count++;
			end
			if (cmd_valid && cmd_ready) begin
				answers_q.push_back(apply_command(action, session_id));
				pending++;
			end
		end
	end

endmodule

[sim/session_slot_table_unit_tb.sv]
// ----------------------------------------------------------------------------
// session_slot_table_unit_tb
// Drives the session slot table with a directed opening and random command
// streams under three idling patterns. Checking is left to
// session_slot_table_checker; this top only makes stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module session_slot_table_unit_tb;

	localparam logic [2:0]                ACT_RSVD5   = 3'd5;
	localparam logic [2:0]                ACT_RSVD6   = 3'd6;
	localparam logic [2:0]                ACT_RSVD7   = 3'd7;
	localparam logic [sst_pkg::SID_W-1:0] SID_TOP     = '1;
	localparam int                        PHASE_WORDS = 640;
	localparam int                        SETTLE      = 32;
	localparam int                        CYCLE_LIMIT = 3000000;

	logic                      clk;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_ready;
	logic [2:0]                action;
	logic [sst_pkg::SID_W-1:0] session_id;
	logic                      rsp_valid;
	logic                      rsp_ready;
	logic [1:0]                status;
	logic [sst_pkg::SID_W-1:0] new_session_id;
	logic                      is_valid;

	int                        errors;
	int                        pending;
	int                        tx_idle_pct;
	int                        rx_idle_pct;
	int                        cycles;
	logic [sst_pkg::SID_W-1:0] id_pool [16];
	logic [3:0]                pool_wr;
	bit                        table_off_seen;

	session_slot_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.action        (action),
		.session_id    (session_id),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.new_session_id(new_session_id),
		.is_valid      (is_valid)
	);

	session_slot_table_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.action        (action),
		.session_id    (session_id),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.status        (status),
		.new_session_id(new_session_id),
		.is_valid      (is_valid),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// ids handed out recently, used to aim closes and queries at live slots
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (status == sst_pkg::STAT_OK && new_session_id != '0) begin
				id_pool[pool_wr] = new_session_id;
				pool_wr          = pool_wr + 1'b1;
			end
			if (status == sst_pkg::STAT_NOT_INIT)
				table_off_seen = 1'b1;
		end
	end

	task automatic send_cmd(input logic [2:0] act, input logic [sst_pkg::SID_W-1:0] sid);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid  <= 1'b1;
		action     <= act;
		session_id <= sid;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [sst_pkg::SID_W-1:0] pick_sid();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return id_pool[$urandom_range(0, 15)];
		else if (r < 65)
			return sst_pkg::SID_W'(id_pool[$urandom_range(0, 15)] +
				($urandom_range(0, 1) ? 1 : -1));
		else if (r < 75)
			return '0;
		else if (r < 80)
			return SID_TOP;
		return sst_pkg::SID_W'($urandom());
	endfunction

	function automatic logic [2:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (table_off_seen && $urandom_range(0, 9) < 7) begin
			table_off_seen = 1'b0;
			return sst_pkg::ACT_INIT;
		end
		if (r < 4)
			return sst_pkg::ACT_INIT;
		else if (r < 7)
			return sst_pkg::ACT_DEINIT;
		else if (r < 37)
			return sst_pkg::ACT_CREATE;
		else if (r < 64)
			return sst_pkg::ACT_CLOSE;
		else if (r < 92)
			return sst_pkg::ACT_QUERY;
		return 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
	endfunction

	task automatic run_random(input int n);
		logic [2:0] act;
		for (int i = 0; i < n; i++) begin
			act = pick_action();
			if (act == sst_pkg::ACT_INIT)
				table_off_seen = 1'b0;
			send_cmd(act, pick_sid());
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		action         = sst_pkg::ACT_INIT;
		session_id     = '0;
		tx_idle_pct    = 13;
		rx_idle_pct    = 88;
		cycles         = 0;
		pool_wr        = '0;
		table_off_seen = 1'b0;
		foreach (id_pool[i])
			id_pool[i] = '0;
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// table off: everything but init is refused
		send_cmd(sst_pkg::ACT_QUERY, '0);
		send_cmd(sst_pkg::ACT_CREATE, SID_TOP);
		send_cmd(sst_pkg::ACT_DEINIT, '0);
		send_cmd(ACT_RSVD5, '0);
		send_cmd(sst_pkg::ACT_INIT, '0);
		send_cmd(sst_pkg::ACT_INIT, SID_TOP);
		repeat (9)
			send_cmd(sst_pkg::ACT_CREATE, '0);
		send_cmd(sst_pkg::ACT_QUERY, 1);
		send_cmd(sst_pkg::ACT_QUERY, 9);
		send_cmd(sst_pkg::ACT_QUERY, SID_TOP);
		send_cmd(sst_pkg::ACT_CLOSE, 5);
		send_cmd(sst_pkg::ACT_CLOSE, 5);
		send_cmd(sst_pkg::ACT_CREATE, '0);
		send_cmd(sst_pkg::ACT_QUERY, 9);
		send_cmd(ACT_RSVD6, SID_TOP);
		send_cmd(ACT_RSVD7, 16'hAAAA);
		send_cmd(sst_pkg::ACT_DEINIT, '0);
		send_cmd(sst_pkg::ACT_QUERY, 1);
		send_cmd(sst_pkg::ACT_INIT, 16'h5555);

		run_random(PHASE_WORDS);
		tx_idle_pct = 88;
		rx_idle_pct = 13;
		run_random(PHASE_WORDS);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(PHASE_WORDS);
		cmd_valid <= 1'b0;

		wait (pending == 0);
		repeat (SETTLE)
			@(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/sst_pkg.sv
rtl/sst_id_ram.sv
rtl/session_slot_table_unit.sv
sim/session_slot_table_checker.sv
sim/session_slot_table_unit_tb.sv
